### rtl/rnf_pkg.sv
// Shared types, character constants and digit encoding for the radix number formatter.
`default_nettype none

package rnf_pkg;

  // Number format selected by the mode register
  typedef enum logic [1:0] {
    MODE_DEC    = 2'd0,
    MODE_HEX    = 2'd1,
    MODE_HEXFIX = 2'd2,
    MODE_OCT    = 2'd3
  } mode_t;

  localparam mode_t MODE_RESET = MODE_HEX;

  // Source of the character loaded into the output register
  typedef enum logic [1:0] {
    SEL_ZERO  = 2'd0,
    SEL_X     = 2'd1,
    SEL_DIGIT = 2'd2
  } emit_sel_t;

  localparam logic [6:0] CHAR_ZERO = 7'h30;
  localparam logic [6:0] CHAR_NINE = 7'h39;
  localparam logic [6:0] CHAR_X    = 7'h78;

  // Fixed-width hex always prints this many digits
  localparam int FIX_DIGITS = 16;

  // Controller to datapath commands
  typedef struct packed {
    logic      load;   // capture a new value
    logic      conv;   // binary-to-BCD conversion steps
    logic      shift;  // drop the top digit
    logic      emit;   // load the output register
    emit_sel_t sel;
    logic      last;
    mode_t     mode;
  } rnf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic top_zero;  // top digit slot holds zero
    logic out_free;  // output register can take a word this cycle
  } rnf_stat_t;

  // Digit 0..15 to ASCII, letters upper case
  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    c = CHAR_ZERO + {3'b000, d};
    if (c > CHAR_NINE) begin
      c = c + 7'd7;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/rnf_datapath.sv
// Datapath: value capture, BCD conversion, digit shift register and output register.
`default_nettype none

module rnf_datapath #(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [63:0]      value,
  input  wire rnf_pkg::rnf_cmd_t cmd,
  output rnf_pkg::rnf_stat_t    stat,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic [6:0]            char_code,
  output logic                  last_char
);

  localparam int OCTD  = (VALUE_WIDTH + 2) / 3;
  localparam int MAXD  = (OCTD > rnf_pkg::FIX_DIGITS) ? OCTD : rnf_pkg::FIX_DIGITS;
  localparam int DW    = MAXD * 4;
  localparam int NSTEP = (VALUE_WIDTH + 3) / 4;
  localparam int CW    = NSTEP * 4;
  localparam int FIXW  = rnf_pkg::FIX_DIGITS * 4;

  logic [DW-1:0] dig;       // digit slots, top slot printed first
  logic [DW-1:0] dig_next;
  logic [CW-1:0] conv;      // binary bits still to feed into the BCD digits
  logic [CW-1:0] conv_next;
  logic [DW-1:0] vpad;
  logic [DW-1:0] load_dig;
  logic [DW-1:0] dab;
  logic [CW-1:0] cv;
  logic [3:0]    top_digit;

  assign vpad      = DW'(value[VALUE_WIDTH-1:0]);
  assign top_digit = dig[DW-1 -: 4];

  always_comb begin
    load_dig = '0;
    unique case (cmd.mode)
      rnf_pkg::MODE_DEC:    load_dig = '0;
      rnf_pkg::MODE_HEX:    load_dig = vpad;
      rnf_pkg::MODE_HEXFIX: load_dig = {vpad[FIXW-1:0], {(DW-FIXW){1'b0}}};
      rnf_pkg::MODE_OCT: begin
        for (int i = 0; i < MAXD; i++) begin
          load_dig[4*i +: 4] = {1'b0, vpad[3*i +: 3]};
        end
      end
      default: load_dig = '0;
    endcase
  end

  // Four double-dabble steps per cycle
  always_comb begin
    dab = dig;
    cv  = conv;
    for (int s = 0; s < 4; s++) begin
      for (int i = 0; i < MAXD; i++) begin
        if (dab[4*i +: 4] >= 4'd5) begin
          dab[4*i +: 4] = dab[4*i +: 4] + 4'd3;
        end
      end
      dab = {dab[DW-2:0], cv[CW-1]};
      cv  = {cv[CW-2:0], 1'b0};
    end
  end

  always_comb begin
    dig_next  = dig;
    conv_next = conv;
    priority if (cmd.load) begin
      dig_next  = load_dig;
      conv_next = CW'(value[VALUE_WIDTH-1:0]);
    end else if (cmd.conv) begin
      dig_next  = dab;
      conv_next = cv;
    end else if (cmd.shift) begin
      dig_next  = {dig[DW-5:0], 4'h0};
    end else begin
      dig_next  = dig;
    end
  end

  always_ff @(posedge clk) begin
    dig  <= dig_next;
    conv <= conv_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last_char <= cmd.last;
      unique case (cmd.sel)
        rnf_pkg::SEL_ZERO:  char_code <= rnf_pkg::CHAR_ZERO;
        rnf_pkg::SEL_X:     char_code <= rnf_pkg::CHAR_X;
        rnf_pkg::SEL_DIGIT: char_code <= rnf_pkg::digit_char(top_digit);
        default:            char_code <= rnf_pkg::CHAR_ZERO;
      endcase
    end
  end

  assign stat.top_zero = (top_digit == 4'h0);
  assign stat.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

### rtl/rnf_ctrl.sv
// Controller: mode register and the sequencing state machine.
`default_nettype none

module rnf_ctrl #(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rnf_pkg::rnf_stat_t stat,
  output rnf_pkg::rnf_cmd_t      cmd
);

  localparam int OCTD  = (VALUE_WIDTH + 2) / 3;
  localparam int MAXD  = (OCTD > rnf_pkg::FIX_DIGITS) ? OCTD : rnf_pkg::FIX_DIGITS;
  localparam int NSTEP = (VALUE_WIDTH + 3) / 4;
  localparam int DCW   = $clog2(MAXD + 1);
  localparam int CCW   = $clog2(NSTEP);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_CONV = 6'b000010,
    ST_SKIP = 6'b000100,
    ST_PFX0 = 6'b001000,
    ST_PFX1 = 6'b010000,
    ST_DIG  = 6'b100000
  } state_t;

  state_t          state, state_next;
  rnf_pkg::mode_t  mode;
  logic [DCW-1:0]  dcnt, dcnt_next;  // digits left to print
  logic [CCW-1:0]  ccnt, ccnt_next;  // conversion cycles left after this one
  logic            accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= rnf_pkg::MODE_RESET;
    end else if (cfg_we) begin
      mode <= rnf_pkg::mode_t'(cfg_wdata);
    end
  end

  always_comb begin
    state_next = state;
    dcnt_next  = dcnt;
    ccnt_next  = ccnt;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.mode   = mode;
    cmd.sel    = rnf_pkg::SEL_DIGIT;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          dcnt_next = DCW'(MAXD);
          ccnt_next = CCW'(NSTEP - 1);
          unique case (mode)
            rnf_pkg::MODE_DEC: state_next = ST_CONV;
            rnf_pkg::MODE_HEXFIX: begin
              dcnt_next  = DCW'(rnf_pkg::FIX_DIGITS);
              state_next = ST_PFX0;
            end
            default: state_next = ST_SKIP;
          endcase
        end
      end
      ST_CONV: begin
        cmd.conv  = 1'b1;
        ccnt_next = ccnt - 1'b1;
        if (ccnt == '0) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (stat.top_zero && dcnt > DCW'(1)) begin
          cmd.shift = 1'b1;
          dcnt_next = dcnt - 1'b1;
        end else if (mode == rnf_pkg::MODE_DEC) begin
          state_next = ST_DIG;
        end else begin
          state_next = ST_PFX0;
        end
      end
      ST_PFX0: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = rnf_pkg::SEL_ZERO;
          state_next = (mode == rnf_pkg::MODE_OCT) ? ST_DIG : ST_PFX1;
        end
      end
      ST_PFX1: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = rnf_pkg::SEL_X;
          state_next = ST_DIG;
        end
      end
      ST_DIG: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = rnf_pkg::SEL_DIGIT;
          cmd.last  = (dcnt == DCW'(1));
          cmd.shift = 1'b1;
          dcnt_next = dcnt - 1'b1;
          if (dcnt == DCW'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      dcnt  <= '0;
      ccnt  <= '0;
    end else begin
      state <= state_next;
      dcnt  <= dcnt_next;
      ccnt  <= ccnt_next;
    end
  end

  a_dcnt_live: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (dcnt != '0))
    else $error("digit count empty while busy");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> (state == ST_IDLE))
    else $error("last word did not end the number");

  a_fix_start: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == rnf_pkg::MODE_HEXFIX) |=>
      (state == ST_PFX0 && dcnt == DCW'(rnf_pkg::FIX_DIGITS)))
    else $error("fixed hex did not start with full digit count");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("emit into an occupied output register");

endmodule

`default_nettype wire

### rtl/radix_number_formatter.sv
// Top level of the radix number formatter: unsigned value in, ASCII text out.
//
// Input (value, in_valid/in_ready): one number per word, low VALUE_WIDTH bits
//   used. One number at a time; in_ready is high only while the block is idle.
// Output (char_code, last_char, out_valid/out_ready): one ASCII character per
//   word, prefix first, then digits most significant first; last_char marks
//   the final character of a number (at most 23: octal prefix plus 22 digits).
// Config: cfg_we writes cfg_wdata into the mode register. The user must write
//   it only between numbers; the block itself does not enforce this. Modes:
//   0 decimal, 1 hex "0x", 2 fixed 16-digit hex "0x", 3 octal "0".
// Sequencing at 64 bits: outside fixed hex the 22-slot digit register drops
//   leading zero slots one per cycle, then prints the remaining digits. Decimal
//   first runs the BCD conversion (4 bits per cycle).
// Stalls: one output register; it reloads in the cycle its word is taken, and
//   while it waits the sequencer holds in place.
// Reset clears the state machine and out_valid and sets the mode to hex with
//   prefix.
`default_nettype none

module radix_number_formatter #(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata,
  input  wire logic [63:0] value,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic [6:0]       char_code,
  output logic             last_char,
  output logic             out_valid,
  input  wire logic        out_ready
);

  rnf_pkg::rnf_cmd_t  cmd;   // sequencer commands
  rnf_pkg::rnf_stat_t stat;  // datapath status

  rnf_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rnf_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .value    (value),
    .cmd      (cmd),
    .stat     (stat),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .char_code(char_code),
    .last_char(last_char)
  );

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the radix number formatter: all formats, random values, stalls.
`timescale 1ns / 1ps

module testbench;

  // One expected output word: a character and its end-of-number flag
  typedef struct {
    logic [6:0] code;
    logic       last;
  } text_char_t;

  localparam logic [6:0]  CHAR_A        = 7'h41;  // first letter digit
  localparam int          IDLE_PCT      = 7;      // idle/stall rate per side, in percent
  localparam int          HOLD_CYCLES   = 300;    // long receiver hold-off
  localparam int          SETTLE_CYCLES = 8;      // block returns to idle after its last char
  localparam int          TAIL_CYCLES   = 64;     // extra wait before the final missing-char check
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int          PHASE_ITEMS   = 48;
  localparam int          MAX_REPORTS   = 40;

  // DUT inputs, known from time zero
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_wdata = 2'd0;
  logic [63:0] value     = 64'd0;
  logic        in_valid  = 1'b0;
  logic        out_ready = 1'b0;

  // DUT outputs
  logic        in_ready;
  logic [6:0]  char_code;
  logic        last_char;
  logic        out_valid;

  // Predictor state: our copy of the mode register (reset: hex with prefix)
  rnf_pkg::mode_t cur_mode = rnf_pkg::MODE_RESET;
  text_char_t  pending_chars [$];   // characters still owed by the block
  text_char_t  want;

  int          errors        = 0;
  int          numbers_sent  = 0;
  int          numbers_done  = 0;
  int          chars_checked = 0;
  int unsigned cycle_count   = 0;

  // Receiver control
  logic        calm         = 1'b0;  // no idling on either side while set
  int          hold_reqs    = 0;     // bumped by a test to ask for a long hold-off
  int          holds_served = 0;
  int          hold_left    = 0;

  radix_number_formatter uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .value     (value),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .last_char (last_char),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d chars still expected",
               $time, cycle_count, pending_chars.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] radix_of(input rnf_pkg::mode_t m);
    case (m)
      rnf_pkg::MODE_DEC: radix_of = 64'd10;
      rnf_pkg::MODE_OCT: radix_of = 64'd8;
      default:           radix_of = 64'd16;
    endcase
  endfunction

  // Digit 0..15 as ASCII, letters upper case
  function automatic logic [6:0] to_ascii(input logic [63:0] d);
    if (d < 10) to_ascii = rnf_pkg::CHAR_ZERO + d[6:0];
    else        to_ascii = CHAR_A + (d[6:0] - 7'd10);
  endfunction

  // Queue up the text the block owes for one accepted number
  function automatic void format_text(input logic [63:0] v);
    logic [6:0]  text [$];
    logic [6:0]  digs [$];
    logic [63:0] rest;
    logic [63:0] base;
    text_char_t  c;
    rest = v;
    base = radix_of(cur_mode);
    // prefix: "0x" for both hex forms, "0" for octal
    if (cur_mode == rnf_pkg::MODE_OCT) begin
      text.push_back(rnf_pkg::CHAR_ZERO);
    end else if (cur_mode != rnf_pkg::MODE_DEC) begin
      text.push_back(rnf_pkg::CHAR_ZERO);
      text.push_back(rnf_pkg::CHAR_X);
    end
    if (cur_mode == rnf_pkg::MODE_HEXFIX) begin
      // always the full digit count, leading zeros kept
      for (int i = 0; i < rnf_pkg::FIX_DIGITS; i++) begin
        digs.push_front(to_ascii(rest % base));
        rest = rest / base;
      end
    end else if (rest == 0) begin
      digs.push_back(rnf_pkg::CHAR_ZERO);   // zero prints as one digit
    end else begin
      while (rest != 0) begin
        digs.push_front(to_ascii(rest % base));
        rest = rest / base;
      end
    end
    foreach (digs[i]) text.push_back(digs[i]);
    foreach (text[i]) begin
      c.code = text[i];
      c.last = (i == text.size() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: ready generation and checking
  // ---------------------------------------------------------------------------

  // Ready drops in about 7% of cycles; a test can ask for a long hold-off,
  // which is counted here so the sender keeps pushing meanwhile.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != holds_served) begin
      holds_served <= hold_reqs;
      hold_left    <= HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Every output word is checked against the oldest owed character
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        errors <= errors + 1;
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected word, expected none, got char %h last %b",
                   $time, char_code, last_char);
      end else begin
        want = pending_chars.pop_front();
        chars_checked <= chars_checked + 1;
        if (want.last) numbers_done <= numbers_done + 1;
        if (char_code !== want.code || last_char !== want.last) begin
          errors <= errors + 1;
          if (errors < MAX_REPORTS) begin
            if (char_code !== want.code)
              $display("%0t: char mismatch, expected %h got %h", $time, want.code, char_code);
            if (last_char !== want.last)
              $display("%0t: last flag mismatch, expected %b got %b",
                       $time, want.last, last_char);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one number and hold it until the block takes it. The edge at the
  // top keeps the drop of valid after the previous word in its own step.
  task automatic send_value(input logic [63:0] v);
    @(posedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) @(posedge clk);
    value    <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    format_text(v);
    numbers_sent++;
  endtask

  // Sender stops until the block has delivered all owed text
  task automatic wait_drained();
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mode writes only happen with the block idle
  task automatic set_mode(input rnf_pkg::mode_t m);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_mode = m;
  endtask

  // Mix of short, long, single-bit and all-ones values
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       v = 64'($urandom_range(3));
      1:       v = v & 64'hFF;
      2:       v = {64{1'b1}} >> $urandom_range(63);
      3:       v = 64'd1 << $urandom_range(63);
      4, 5:    v = v >> $urandom_range(63);
      default: ;
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // No mode write yet: the register must come up as hex with prefix
  task automatic test_reset_mode();
    send_value(64'd0);
    send_value(64'h0123_4567_89AB_CDEF);
  endtask

  // Per format: zero, one, largest digit, first two-digit value, all ones
  task automatic test_format_edges();
    logic [63:0] r;
    for (int k = 0; k < 4; k++) begin
      set_mode(rnf_pkg::mode_t'(k));
      r = radix_of(cur_mode);
      send_value(64'd0);
      send_value(64'd1);
      send_value(r - 1);
      send_value(r);
      send_value({64{1'b1}});
    end
  endtask

  // Phases of random values; fixed order through all four modes, then random modes
  task automatic test_random_values();
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       set_mode(rnf_pkg::MODE_DEC);
        1:       set_mode(rnf_pkg::MODE_OCT);
        2:       set_mode(rnf_pkg::MODE_HEX);
        3:       set_mode(rnf_pkg::MODE_HEXFIX);
        default: set_mode(rnf_pkg::mode_t'($urandom_range(3)));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) send_value(random_value());
    end
  endtask

  // Receiver holds off for a long stretch while numbers keep coming, so the
  // output register fills and the block stops taking input
  task automatic test_output_hold();
    set_mode(rnf_pkg::MODE_OCT);
    hold_reqs++;
    for (int i = 0; i < 24; i++) send_value(random_value());
    wait_drained();
  endtask

  // Back-to-back numbers, no idling on either side
  task automatic test_calm_burst();
    set_mode(rnf_pkg::mode_t'($urandom_range(3)));
    calm = 1'b1;
    for (int i = 0; i < 40; i++) send_value(random_value());
    wait_drained();
    calm = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_mode();
    test_format_edges();
    test_output_hold();
    test_random_values();
    test_calm_burst();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0) begin
      errors++;
      $display("%0t: %0d chars never arrived", $time, pending_chars.size());
    end

    $display("Formatted %0d of %0d numbers, %0d chars checked, in all four formats",
             numbers_done, numbers_sent, chars_checked);
    $display("incl. zero, all-ones, radix edges, a %0d-cycle output hold and a calm burst",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
